### sv/cfbp_pkg.sv
// package for the can frame bit packer: request and response structs,
// command codes, field widths and default parameter values. no dependencies.
package cfbp_pkg;

	localparam int ID_EXT_BITS       = 29;
	localparam int ID_STD_BITS       = 11;
	localparam int BYTE_BITS         = 8;
	localparam int PAYLOAD_BYTES_DEF = 8;
	localparam int ACCESS_WIDTH_DEF  = 32;
	localparam int ACCESS_WIDTH_MAX  = 64;

	localparam int CMD_W   = 2;
	localparam int VALUE_W = 32;
	localparam int FWIDTH_W = 6;
	localparam int PAYLD_W = 64;
	localparam int LEN_W   = 4;
	localparam int POS_W   = 7;

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]       cmd;
		logic [VALUE_W-1:0]     field_value;
		logic [FWIDTH_W-1:0]    field_width;
		logic [ID_EXT_BITS-1:0] load_ident;
		logic [PAYLD_W-1:0]     load_payload;
		logic [LEN_W-1:0]       load_length;
	} req_t;

	typedef struct packed {
		logic [VALUE_W-1:0]     read_value;
		logic [ID_EXT_BITS-1:0] frame_ident;
		logic [PAYLD_W-1:0]     frame_payload;
		logic [LEN_W-1:0]       frame_length;
		logic [POS_W-1:0]       bit_position;
		logic                   overflow;
	} rsp_t;

endpackage

### sv/can_frame_bit_packer.sv
// top level of the can frame bit packer: msb-first field writes and reads over
// an identifier-plus-payload bit vector. depends on cfbp_pkg.
//
// The frame is one bit vector: the identifier (11 bits, or 29 when extended_id
// is set) followed by PAYLOAD_BYTES payload bytes, each taken bit 7 first. A
// write ORs a field of up to ACCESS_WIDTH bits in at the current position and
// advances it; a read pulls the same-sized field out right-aligned; load takes
// a whole received frame and rewinds; clear empties the frame. Accesses that
// run off the end saturate the position at capacity and flag overflow; bits
// past the end read as zero. Every request yields exactly one response carrying
// the frame state after that request. Throughput is one request per clock
// while the response side is not stalling: the frame state registers are
// updated in the same cycle the request leaves the input register, so
// consecutive requests chain with no bubble. A request passes through the
// input register, then the response register. extended_id writes are taken
// at any time on the cfg channel but only land while the position is zero.
module can_frame_bit_packer #(
	parameter int PAYLOAD_BYTES = cfbp_pkg::PAYLOAD_BYTES_DEF,
	parameter int ACCESS_WIDTH  = cfbp_pkg::ACCESS_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// request channel
	input  logic             req_valid,
	output logic             req_stall,
	input  cfbp_pkg::req_t   req_data,
	// response channel
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output cfbp_pkg::rsp_t   rsp_data,
	// configuration: extended_id
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_data
);

	// frame geometry
	localparam int PAY_W   = cfbp_pkg::BYTE_BITS * PAYLOAD_BYTES;
	localparam int ID_EXT  = cfbp_pkg::ID_EXT_BITS;
	localparam int ID_STD  = cfbp_pkg::ID_STD_BITS;
	localparam int CAPM    = ID_EXT + PAY_W;          // longest frame in bits
	localparam int AW      = ACCESS_WIDTH;
	localparam int WW      = $clog2(AW + 1);          // saturated width
	localparam int POS_W   = cfbp_pkg::POS_W;
	localparam int SUM_W   = POS_W + 1;
	localparam int BC_W    = $clog2(PAYLOAD_BYTES + 1);
	localparam logic [POS_W-1:0] CAP_EXT = POS_W'(ID_EXT + PAY_W);
	localparam logic [POS_W-1:0] CAP_STD = POS_W'(ID_STD + PAY_W);
	localparam logic [POS_W-1:0] IDS_EXT = POS_W'(ID_EXT);
	localparam logic [POS_W-1:0] IDS_STD = POS_W'(ID_STD);
	localparam logic [BC_W-1:0]  BC_MAX  = BC_W'(PAYLOAD_BYTES);

	// frame state
	logic                 ext_q;
	logic [ID_EXT-1:0]    ident_q;
	logic [PAY_W-1:0]     pay_q;      // byte i at [8i+7:8i]
	logic [POS_W-1:0]     pos_q;
	logic [BC_W-1:0]      bc_q;

	// input register and response register
	logic                 vld_s1;
	cfbp_pkg::req_t       req_s1;
	logic                 vld_s2;
	cfbp_pkg::rsp_t       rsp_s2;

	logic                 advance;

	// next-state values
	logic [ID_EXT-1:0]    ident_nxt;
	logic [PAY_W-1:0]     pay_nxt;
	logic [POS_W-1:0]     pos_nxt;
	logic [BC_W-1:0]      bc_nxt;
	logic                 ovf_nxt;
	logic [cfbp_pkg::VALUE_W-1:0] rd_nxt;

	// datapath intermediates
	logic [POS_W-1:0]     cap_cur;
	logic [POS_W-1:0]     ids_cur;
	logic [WW-1:0]        w_eff;
	logic [CAPM-1:0]      vec_ext;
	logic [CAPM-1:0]      vec_std;
	logic [CAPM-1:0]      vec;
	logic [CAPM+AW-1:0]   rd_wide;
	logic [AW-1:0]        rd_win;
	logic [AW-1:0]        rd_field;
	logic [AW-1:0]        wr_raw;
	logic [AW-1:0]        wr_left;
	logic [CAPM+AW-1:0]   wr_wide;
	logic [CAPM-1:0]      wr_bits;
	logic [ID_EXT-1:0]    ident_or;
	logic [PAY_W-1:0]     pay_or;
	logic [SUM_W-1:0]     pos_sum;
	logic                 ovf_acc;
	logic [POS_W-1:0]     pos_acc;
	logic [POS_W-1:0]     byte_span;
	logic [BC_W-1:0]      bc_wr;
	logic [BC_W-1:0]      bc_ld;

	// handshake: the input register moves whenever the response slot is free
	// or being emptied; the request side is only held off when it cannot
	assign advance   = vld_s1 && (!vld_s2 || !rsp_stall);
	assign req_stall = vld_s1 && !advance;
	assign rsp_valid = vld_s2;
	assign rsp_data  = rsp_s2;
	assign cfg_ready = 1'b1;

	// geometry for the current mode
	assign cap_cur = ext_q ? CAP_EXT : CAP_STD;
	assign ids_cur = ext_q ? IDS_EXT : IDS_STD;

	// field width clipped to the access width
	assign w_eff = (32'(req_s1.field_width) > AW) ? WW'(AW) : WW'(req_s1.field_width);

	// lay the frame out as one msb-first vector, padded with zeros past the
	// end of a standard-id frame so reads off the end come back zero
	always_comb begin
		vec_ext = '0;
		vec_std = '0;
		vec_ext[CAPM-1 -: ID_EXT] = ident_q;
		vec_std[CAPM-1 -: ID_STD] = ident_q[ID_STD-1:0];
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			vec_ext[CAPM-1-ID_EXT-8*i -: 8] = pay_q[8*i +: 8];
			vec_std[CAPM-1-ID_STD-8*i -: 8] = pay_q[8*i +: 8];
		end
	end

	assign vec = ext_q ? vec_ext : vec_std;

	// read path: shift the window to the top, then right-align w_eff bits
	assign rd_wide  = {vec, {AW{1'b0}}} << pos_q;
	assign rd_win   = rd_wide[CAPM+AW-1 -: AW];
	assign rd_field = rd_win >> (WW'(AW) - w_eff);

	// write path: mask the value, left-align it, drop it in at the position;
	// anything shifted past the frame end is lost
	assign wr_raw  = AW'(req_s1.field_value) & ~({AW{1'b1}} << w_eff);
	assign wr_left = wr_raw << (WW'(AW) - w_eff);
	assign wr_wide = {wr_left, {CAPM{1'b0}}} >> pos_q;
	assign wr_bits = wr_wide[CAPM+AW-1 -: CAPM];

	// map the written bits back onto identifier and payload bytes; in standard
	// mode the upper identifier bits are left alone
	always_comb begin
		ident_or = ext_q ? wr_bits[CAPM-1 -: ID_EXT]
		                 : ID_EXT'(wr_bits[CAPM-1 -: ID_STD]);
		pay_or   = '0;
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			pay_or[8*i +: 8] = ext_q ? wr_bits[CAPM-1-ID_EXT-8*i -: 8]
			                         : wr_bits[CAPM-1-ID_STD-8*i -: 8];
		end
	end

	// position advance with saturation at capacity
	assign pos_sum = SUM_W'(pos_q) + SUM_W'(w_eff);
	assign ovf_acc = pos_sum > SUM_W'(cap_cur);
	assign pos_acc = ovf_acc ? cap_cur : pos_sum[POS_W-1:0];

	// payload bytes touched by everything below the new position
	assign byte_span = (pos_acc - ids_cur + POS_W'(7)) >> 3;
	assign bc_wr = (pos_acc <= ids_cur) ? '0
	             : (byte_span > POS_W'(PAYLOAD_BYTES)) ? BC_MAX : BC_W'(byte_span);

	// load length clipped to the payload size
	assign bc_ld = (32'(req_s1.load_length) > PAYLOAD_BYTES) ? BC_MAX
	                                                         : BC_W'(req_s1.load_length);

	// command decode
	always_comb begin
		ident_nxt = ident_q;
		pay_nxt   = pay_q;
		pos_nxt   = pos_q;
		bc_nxt    = bc_q;
		ovf_nxt   = 1'b0;
		rd_nxt    = '0;
		unique case (req_s1.cmd)
			cfbp_pkg::CMD_WRITE: begin
				if (w_eff != '0) begin
					ident_nxt = ident_q | ident_or;
					pay_nxt   = pay_q | pay_or;
					pos_nxt   = pos_acc;
					bc_nxt    = bc_wr;
					ovf_nxt   = ovf_acc;
				end
			end
			cfbp_pkg::CMD_READ: begin
				if (w_eff != '0) begin
					rd_nxt  = cfbp_pkg::VALUE_W'(rd_field);
					pos_nxt = pos_acc;
					ovf_nxt = ovf_acc;
				end
			end
			cfbp_pkg::CMD_LOAD: begin
				ident_nxt = ext_q ? req_s1.load_ident
				                  : ID_EXT'(req_s1.load_ident[ID_STD-1:0]);
				pay_nxt   = req_s1.load_payload[PAY_W-1:0];
				bc_nxt    = bc_ld;
				pos_nxt   = '0;
			end
			cfbp_pkg::CMD_CLEAR: begin
				ident_nxt = '0;
				pay_nxt   = '0;
				bc_nxt    = '0;
				pos_nxt   = '0;
			end
			default: begin
				ident_nxt = ident_q;
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req_data;
		end
	end

	// frame state and mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q   <= 1'b0;
			ident_q <= '0;
			pay_q   <= '0;
			pos_q   <= '0;
			bc_q    <= '0;
		end else begin
			// mode is locked while the position is nonzero
			if (cfg_valid && cfg_ready && pos_q == '0) begin
				ext_q <= cfg_data;
			end
			if (advance) begin
				ident_q <= ident_nxt;
				pay_q   <= pay_nxt;
				pos_q   <= pos_nxt;
				bc_q    <= bc_nxt;
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2.read_value    <= rd_nxt;
			rsp_s2.frame_ident   <= ident_nxt;
			rsp_s2.frame_payload <= cfbp_pkg::PAYLD_W'(pay_nxt);
			rsp_s2.frame_length  <= cfbp_pkg::LEN_W'(bc_nxt);
			rsp_s2.bit_position  <= pos_nxt;
			rsp_s2.overflow      <= ovf_nxt;
		end
	end

	// position never runs past the end of the frame
	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= cap_cur)
		else $error("position beyond frame capacity");

	// byte count never exceeds the payload size
	a_len_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		bc_q <= BC_MAX)
		else $error("byte count beyond payload size");

	// an overflowing access always leaves the position parked at capacity
	a_ovf_parks: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ovf_nxt |=> rsp_s2.bit_position == cap_cur && pos_q == cap_cur)
		else $error("overflow without saturated position");

	// a request that leaves the input register always lands in the response slot
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> vld_s2)
		else $error("request lost between stages");

endmodule

### tb/sv/can_frame_bit_packer_tb.sv
// testbench for can_frame_bit_packer: directed and random field requests checked
// against a behavioral frame packer kept in step at every accepted request.
// depends on cfbp_pkg and the can_frame_bit_packer rtl.
`timescale 1ns / 100ps

module can_frame_bit_packer_tb;

	localparam int IDLE_PCT      = 26;
	localparam int SETTLE_CYCLES = 4;
	localparam int QUIET_LIMIT   = 2000;  // longest legal quiet stretch is the HOLD_CYCLES hold
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_ITEMS  = 1750;
	localparam int PHASES        = 6;
	localparam int MAX_REPORTS   = 40;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	cfbp_pkg::req_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	cfbp_pkg::rsp_t rsp_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data  = 1'b0;

	// knobs shared by sender and receiver
	int idle_pct        = IDLE_PCT;
	int rsp_hold_cycles = 0;
	int mismatch_count  = 0;
	int quiet_cycles    = 0;

	// behavioral copy of the frame state and the mode register
	logic          mdl_ext;
	logic [28:0]   mdl_ident;
	logic [63:0]   mdl_payload;
	int unsigned   mdl_pos;
	int unsigned   mdl_len;

	cfbp_pkg::rsp_t frame_expect_q[$];

	can_frame_bit_packer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// frame packer prediction
	// ------------------------------------------------------------------

	// identifier length in bits for the current mode
	function automatic int unsigned ident_len();
		return mdl_ext ? cfbp_pkg::ID_EXT_BITS : cfbp_pkg::ID_STD_BITS;
	endfunction

	// frame bit p: identifier msb first, then payload bytes bit 7 first
	function automatic logic frame_bit(int unsigned p);
		int unsigned ids;
		int unsigned q;
		ids = ident_len();
		if (p < ids)
			return mdl_ident[ids-1-p];
		q = p - ids;
		return mdl_payload[8*(q/8) + 7 - (q%8)];
	endfunction

	function automatic void frame_set_bit(int unsigned p);
		int unsigned ids;
		int unsigned q;
		ids = ident_len();
		if (p < ids) begin
			mdl_ident[ids-1-p] = 1'b1;
		end else begin
			q = p - ids;
			mdl_payload[8*(q/8) + 7 - (q%8)] = 1'b1;
		end
	endfunction

	// applies one request to the frame state, returns the response it must produce
	function automatic cfbp_pkg::rsp_t pack_apply(cfbp_pkg::req_t r);
		cfbp_pkg::rsp_t o;
		int unsigned w;
		int unsigned cap;
		int unsigned p;
		int unsigned n;
		int unsigned i;
		logic [31:0] rd;
		logic        ovf;
		w   = 32'(r.field_width);
		if (w > cfbp_pkg::ACCESS_WIDTH_DEF)
			w = cfbp_pkg::ACCESS_WIDTH_DEF;  // wide fields saturate to the access width
		cap = ident_len() + cfbp_pkg::BYTE_BITS * cfbp_pkg::PAYLOAD_BYTES_DEF;
		rd  = '0;
		ovf = 1'b0;
		case (r.cmd)
			cfbp_pkg::CMD_WRITE: begin
				if (w > 0) begin
					for (i = 0; i < w; i++) begin
						p = mdl_pos + i;
						if (p < cap && r.field_value[w-1-i])
							frame_set_bit(p);
					end
					if (mdl_pos + w > cap) begin
						ovf     = 1'b1;
						mdl_pos = cap;
					end else begin
						mdl_pos = mdl_pos + w;
					end
					// byte count covers every payload byte touched below the position
					if (mdl_pos > ident_len()) begin
						n       = (mdl_pos - ident_len() + 7) / 8;
						mdl_len = (n > cfbp_pkg::PAYLOAD_BYTES_DEF)
							? cfbp_pkg::PAYLOAD_BYTES_DEF : n;
					end else begin
						mdl_len = 0;
					end
				end
			end
			cfbp_pkg::CMD_READ: begin
				if (w > 0) begin
					for (i = 0; i < w; i++) begin
						p  = mdl_pos + i;
						rd = {rd[30:0], (p < cap) ? frame_bit(p) : 1'b0};
					end
					if (mdl_pos + w > cap) begin
						ovf     = 1'b1;
						mdl_pos = cap;
					end else begin
						mdl_pos = mdl_pos + w;
					end
				end
			end
			cfbp_pkg::CMD_LOAD: begin
				mdl_ident   = mdl_ext ? r.load_ident : (r.load_ident & 29'h7FF);
				mdl_payload = r.load_payload;
				mdl_len     = 32'(r.load_length);
				if (mdl_len > cfbp_pkg::PAYLOAD_BYTES_DEF)
					mdl_len = cfbp_pkg::PAYLOAD_BYTES_DEF;
				mdl_pos     = 0;
			end
			cfbp_pkg::CMD_CLEAR: begin
				mdl_ident   = '0;
				mdl_payload = '0;
				mdl_len     = 0;
				mdl_pos     = 0;
			end
			default: ;
		endcase
		o.read_value    = rd;
		o.frame_ident   = mdl_ident;
		o.frame_payload = mdl_payload;
		o.frame_length  = mdl_len[3:0];
		o.bit_position  = mdl_pos[6:0];
		o.overflow      = ovf;
		return o;
	endfunction

	// ------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------

	// request with random load fields; load tests override them
	function automatic cfbp_pkg::req_t make_req(logic [1:0] cmd, logic [31:0] value,
		int width);
		cfbp_pkg::req_t r;
		r.cmd          = cmd;
		r.field_value  = value;
		r.field_width  = width[5:0];
		r.load_ident   = 29'($urandom);
		r.load_payload = {$urandom, $urandom};
		r.load_length  = 4'($urandom_range(15));
		return r;
	endfunction

	function automatic cfbp_pkg::req_t make_load(logic [28:0] ident, logic [63:0] payload,
		logic [3:0] length);
		cfbp_pkg::req_t r;
		r              = make_req(cfbp_pkg::CMD_LOAD, $urandom, $urandom_range(63));
		r.load_ident   = ident;
		r.load_payload = payload;
		r.load_length  = length;
		return r;
	endfunction

	// mostly in range, sometimes zero, sometimes above the access width
	function automatic int rand_width();
		int roll;
		roll = $urandom_range(99);
		if (roll < 5)
			return 0;
		if (roll < 12)
			return $urandom_range(63, 33);
		return $urandom_range(32, 1);
	endfunction

	// presents one request, holds it through any stall, predicts at acceptance.
	// valid is left high so back-to-back requests need no second assignment
	task automatic send_req(input cfbp_pkg::req_t r);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		do
			@(posedge clk);
		while (req_stall);
		frame_expect_q.push_back(pack_apply(r));
	endtask

	// stop offering requests and wait out every outstanding response
	task automatic drain_responses();
		req_valid <= 1'b0;
		@(posedge clk);
		while (frame_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mode register write, only with the block idle; lands only at position zero
	task automatic write_mode(input logic ext);
		drain_responses();
		cfg_valid <= 1'b1;
		cfg_data  <= ext;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (mdl_pos == 0)
			mdl_ext = ext;
	endtask

	// ------------------------------------------------------------------
	// response side: random stall, long hold on request, in-order check
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (mismatch_count < MAX_REPORTS)
			$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : rsp_side
		cfbp_pkg::rsp_t want;
		// sample handshake as it stood at this edge
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (frame_expect_q.size() == 0) begin
				report_mismatch("response with nothing pending", 64'd1, 64'd0);
			end else begin
				want = frame_expect_q.pop_front();
				if (rsp_data.read_value !== want.read_value)
					report_mismatch("read_value", 64'(rsp_data.read_value),
						64'(want.read_value));
				if (rsp_data.frame_ident !== want.frame_ident)
					report_mismatch("frame_ident", 64'(rsp_data.frame_ident),
						64'(want.frame_ident));
				if (rsp_data.frame_payload !== want.frame_payload)
					report_mismatch("frame_payload", rsp_data.frame_payload,
						want.frame_payload);
				if (rsp_data.frame_length !== want.frame_length)
					report_mismatch("frame_length", 64'(rsp_data.frame_length),
						64'(want.frame_length));
				if (rsp_data.bit_position !== want.bit_position)
					report_mismatch("bit_position", 64'(rsp_data.bit_position),
						64'(want.bit_position));
				if (rsp_data.overflow !== want.overflow)
					report_mismatch("overflow", 64'(rsp_data.overflow),
						64'(want.overflow));
			end
		end
		// long hold-off counts down here, otherwise random stall
		if (rsp_hold_cycles > 0) begin
			rsp_hold_cycles = rsp_hold_cycles - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	// watchdog on cycles where no channel moves anything
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** can_frame_bit_packer: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// zero width, exact fill to capacity, saturated wide field, write overrun
	task automatic test_field_writes();
		send_req(make_req(cfbp_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 32));
		send_req(make_req(cfbp_pkg::CMD_WRITE, 32'hFFFF_FFFF, 0));
		send_req(make_req(cfbp_pkg::CMD_WRITE, 32'h0000_05A5, 11));
		send_req(make_req(cfbp_pkg::CMD_WRITE, 32'hAAAA_AAAA, 32));
		// 63 saturates to 32 and lands exactly on capacity, no overflow
		send_req(make_req(cfbp_pkg::CMD_WRITE, 32'h1234_5678, 63));
		send_req(make_req(cfbp_pkg::CMD_WRITE, 32'hFFFF_FFFF, 1));
		send_req(make_req(cfbp_pkg::CMD_WRITE, 32'hFFFF_FFFF, 32));
	endtask

	// load with masked identifier and saturated length, reads through the end
	task automatic test_field_reads();
		send_req(make_load(29'h1FFF_FFFF, 64'hF0E1_D2C3_B4A5_9687, 4'hF));
		send_req(make_req(cfbp_pkg::CMD_READ, 32'hFFFF_FFFF, 0));
		send_req(make_req(cfbp_pkg::CMD_READ, 32'h0, 7));
		send_req(make_req(cfbp_pkg::CMD_READ, 32'h0, 32));
		send_req(make_req(cfbp_pkg::CMD_READ, 32'h0, 40));
		// runs past the end: tail reads zero, position saturates
		send_req(make_req(cfbp_pkg::CMD_READ, 32'h0, 8));
		send_req(make_load(29'h0, 64'h0, 4'h0));
		send_req(make_load(29'h1555_5555, 64'hFFFF_FFFF_FFFF_FFFF, 4'h8));
		send_req(make_req(cfbp_pkg::CMD_CLEAR, 32'h0, 0));
	endtask

	// mode write ignored mid-frame, accepted after clear, 29-bit frame overrun
	task automatic test_mode_change();
		send_req(make_req(cfbp_pkg::CMD_WRITE, 32'h5, 3));
		write_mode(1'b1);
		send_req(make_req(cfbp_pkg::CMD_CLEAR, 32'h0, 0));
		write_mode(1'b1);
		send_req(make_req(cfbp_pkg::CMD_WRITE, 32'h1FFF_FFFF, 29));
		send_req(make_req(cfbp_pkg::CMD_WRITE, 32'hDEAD_BEEF, 32));
		send_req(make_req(cfbp_pkg::CMD_WRITE, 32'hFFFF_FFFF, 32));
		send_req(make_req(cfbp_pkg::CMD_WRITE, 32'hFFFF_FFFF, 16));
		send_req(make_load(29'h1ABC_DEF1, 64'h0123_4567_89AB_CDEF, 4'h9));
		send_req(make_req(cfbp_pkg::CMD_READ, 32'h0, 32));
		send_req(make_req(cfbp_pkg::CMD_CLEAR, 32'h0, 0));
		write_mode(1'b0);
	endtask

	// one random sequence: write burst after clear, read burst after load, or noise
	task automatic run_sequence(output int sent);
		int kind;
		int n;
		int i;
		kind = $urandom_range(9);
		n    = $urandom_range(9, 3);
		sent = 0;
		if (kind <= 3) begin
			send_req(make_req(cfbp_pkg::CMD_CLEAR, $urandom, $urandom_range(63)));
			sent++;
			for (i = 0; i < n; i++) begin
				send_req(make_req(cfbp_pkg::CMD_WRITE, $urandom, rand_width()));
				sent++;
			end
		end else if (kind <= 6) begin
			send_req(make_load(29'($urandom), {$urandom, $urandom},
				4'($urandom_range(15))));
			sent++;
			for (i = 0; i < n; i++) begin
				send_req(make_req(cfbp_pkg::CMD_READ, $urandom, rand_width()));
				sent++;
			end
		end else begin
			n = $urandom_range(4, 1);
			for (i = 0; i < n; i++) begin
				send_req(make_req(2'($urandom_range(3)), $urandom, $urandom_range(63)));
				sent++;
			end
		end
	endtask

	// receiver holds off long enough for the block to fill and stall its input
	task automatic test_backpressure();
		int sent;
		int total;
		drain_responses();
		idle_pct        = 0;
		rsp_hold_cycles = HOLD_CYCLES;
		total           = 0;
		while (total < 40) begin
			run_sequence(sent);
			total += sent;
		end
		idle_pct = IDLE_PCT;
		drain_responses();
	endtask

	// sender stops mid-stream until every response is back, then carries on
	task automatic test_sender_pause();
		int sent;
		run_sequence(sent);
		run_sequence(sent);
		drain_responses();
		run_sequence(sent);
		run_sequence(sent);
	endtask

	// random phases across both modes; one phase runs with no idling at all
	task automatic test_random_traffic();
		int phase;
		int sent;
		int total;
		logic ext;
		for (phase = 0; phase < PHASES; phase++) begin
			drain_responses();
			// usually rewind first so the mode write takes effect
			if ($urandom_range(3) != 0)
				send_req(make_req(cfbp_pkg::CMD_CLEAR, $urandom, $urandom_range(63)));
			case (phase)
				0, 3: ext = 1'b0;
				1, 2: ext = 1'b1;
				default: ext = 1'($urandom_range(1));
			endcase
			write_mode(ext);
			idle_pct = (phase == 2) ? 0 : IDLE_PCT;
			total    = 0;
			while (total < RANDOM_ITEMS / PHASES) begin
				run_sequence(sent);
				total += sent;
			end
		end
		idle_pct = IDLE_PCT;
	endtask

	initial begin
		mdl_ext     = 1'b0;
		mdl_ident   = '0;
		mdl_payload = '0;
		mdl_pos     = 0;
		mdl_len     = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_writes();
		test_field_reads();
		test_mode_change();
		test_backpressure();
		test_sender_pause();
		test_random_traffic();

		drain_responses();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("** can_frame_bit_packer: PASSED **");
		else
			$display("** can_frame_bit_packer: FAILED **");
		$finish;
	end

endmodule

### filelist.f
sv/cfbp_pkg.sv
sv/can_frame_bit_packer.sv
tb/sv/can_frame_bit_packer_tb.sv
